### hdl/stsm_pkg.sv
// Shared types, constants and arithmetic helpers of the speed/accel telemetry smoother.
// No dependencies; every other file of the block imports this package.
package stsm_pkg;

  // Field widths
  localparam int unsigned SpeedW = 17;   // signed speed, 1/256 km/h
  localparam int unsigned TopSpW = 16;   // peak |speed|
  localparam int unsigned AccelW = 18;   // signed accel, 1/4096 g
  localparam int unsigned TopAcW = 17;   // peak |accel|
  localparam int unsigned TimeW  = 32;
  localparam int unsigned AlphaW = 9;
  localparam int unsigned BandW  = 12;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 12;

  // Fixed-point constants
  localparam int SpeedLimit = 51200;
  localparam int unsigned AccelLimit = 65536;
  localparam int unsigned AlphaOne = 256;
  localparam int unsigned AccelNumK = 4000000;  // 1000 * 4096 / 1.024 ...
  localparam int unsigned AccelDenK = 8829;     // 3.6 * 9.81 * 250

  // Serial divider geometry
  localparam int unsigned NumW  = 39;            // |dv| * AccelNumK
  localparam int unsigned DenW  = 46;            // AccelDenK * dt
  localparam int unsigned DivW  = 47;            // dividend / divisor width
  localparam int unsigned QuotW = 18;            // quotient bits, one per step
  localparam int unsigned ShW   = DivW + QuotW - 1;
  localparam int unsigned CntW  = $clog2(QuotW);

  // Reset values of the configuration registers
  localparam logic [AlphaW-1:0] SpeedAlphaRst = AlphaW'(90);
  localparam logic [AlphaW-1:0] AccelAlphaRst = AlphaW'(64);
  localparam logic [BandW-1:0]  BandRst       = BandW'(77);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SPEED_ALPHA     = 2'd0,
    CFG_ACCEL_ALPHA     = 2'd1,
    CFG_STANDSTILL_BAND = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KIND_SAMPLE    = 1'b0,
    KIND_LINK_LOST = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPEED,
    ST_BAND,
    ST_DIV,
    ST_ACCEL,
    ST_PEAK,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QuotW-1:0] quot;
  } div_rsp_t;

  // One exponential average step: old + floor((alpha * (x - old) + 128) / 256).
  // Alpha above one is treated as one.
  function automatic logic signed [18:0] ema_step(input logic signed [18:0] old,
                                                  input logic signed [18:0] x,
                                                  input logic [AlphaW-1:0] alpha);
    logic [AlphaW-1:0]  alpha_c;
    logic signed [19:0] diff;
    logic signed [29:0] prod;
    logic signed [29:0] shifted;
    alpha_c = (alpha > AlphaW'(AlphaOne)) ? AlphaW'(AlphaOne) : alpha;
    diff    = {x[18], x} - {old[18], old};
    prod    = $signed({1'b0, alpha_c}) * diff;
    prod    = prod + 30'sd128;
    shifted = prod >>> 8;
    return old + shifted[18:0];
  endfunction

endpackage

### hdl/stsm_in_if.sv
// Input channel of the telemetry smoother: valid/ready plus one sample or link-lost beat.
// Depends on stsm_pkg for field widths.
interface stsm_in_if
  import stsm_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic signed [SpeedW-1:0] speed_raw;
  logic [TimeW-1:0]         time_ms;

  modport source (output valid, output kind, output speed_raw, output time_ms, input ready);
  modport sink   (input valid, input kind, input speed_raw, input time_ms, output ready);
endinterface

### hdl/stsm_out_if.sv
// Output channel of the telemetry smoother: valid/ready plus one result beat.
// Depends on stsm_pkg for field widths.
interface stsm_out_if
  import stsm_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [SpeedW-1:0] smoothed_speed;
  logic [TopSpW-1:0]        max_speed;
  logic signed [AccelW-1:0] accel_g;
  logic [TopAcW-1:0]        peak_g;

  modport source (output valid, output smoothed_speed, output max_speed, output accel_g,
                  output peak_g, input ready);
  modport sink   (input valid, input smoothed_speed, input max_speed, input accel_g,
                  input peak_g, output ready);
endinterface

### hdl/stsm_div.sv
// Restoring serial divider, one quotient bit per cycle, most significant bit first.
// Depends on stsm_pkg for widths and the request/response structs.
module stsm_div
  import stsm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DivW-1:0]  rem_q, rem_d;
  logic [ShW-1:0]   dsh_q, dsh_d;
  logic [QuotW-1:0] quot_q, quot_d;
  logic             ge;

  assign ge = {{(ShW-DivW){1'b0}}, rem_q} >= dsh_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(QuotW - 1);
      rem_d  = req_i.dividend;
      dsh_d  = {req_i.divisor, {(QuotW-1){1'b0}}};
      quot_d = '0;
    end else if (busy_q) begin
      // compare, subtract, shift in one quotient bit
      if (ge) begin
        rem_d = rem_q - dsh_q[DivW-1:0];
      end
      quot_d = {quot_q[QuotW-2:0], ge};
      dsh_d  = dsh_q >> 1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

### hdl/speed_accel_telemetry_smoother.sv
// Top level of the speed/accel telemetry smoother: sequencer, state and result register.
// Depends on stsm_pkg, stsm_in_if, stsm_out_if and stsm_div.
//
// One beat in, one beat out. A speed sample updates the averaged speed (zeroed
// inside the standstill band) and the peak |speed|; when a nonzero earlier
// timestamp exists and time has moved forward it also derives the acceleration
// (1/4096 g, saturated to 16 g), averages it and tracks its peak. A link-lost
// beat clears the averaged speed, the averaged acceleration and the stored
// timestamp. The block takes one beat at a time: a link-lost beat goes straight
// to the result register, a sample without derivation passes the speed and band
// steps, and a sample with derivation then also waits for the 18-step serial
// divider that forms the rounded quotient speed change / elapsed time. The
// result sits in an output register, so the next beat is accepted while the
// previous result still waits for its sink. Configuration registers are written
// through cfg_we_i/cfg_idx_i/cfg_wdata_i, by the user only while the block is idle;
// the block does not enforce this. An index beyond the register list is ignored.
module speed_accel_telemetry_smoother
  import stsm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  stsm_in_if.sink             in_i,
  stsm_out_if.source          out_o
);

  state_e state_q, state_d;

  // configuration
  logic [AlphaW-1:0] speed_alpha_q;
  logic [AlphaW-1:0] accel_alpha_q;
  logic [BandW-1:0]  band_q;

  // architectural state
  logic signed [SpeedW-1:0] avg_spd_q;
  logic [TopSpW-1:0]        top_spd_q;
  logic signed [SpeedW-1:0] prev_spd_q;
  logic [TimeW-1:0]         prev_time_q;
  logic signed [AccelW-1:0] avg_acc_q;
  logic [TopAcW-1:0]        top_acc_q;

  // per-beat working registers
  logic signed [SpeedW-1:0] raw_q;
  logic [TimeW-1:0]         now_q;
  logic                     acc_go_q;
  logic                     neg_q;
  logic [NumW-1:0]          num_q;
  logic [DenW-1:0]          den_q;
  logic signed [AccelW-1:0] inst_q;

  // result register
  logic                     out_valid_q;
  logic signed [SpeedW-1:0] out_spd_q;
  logic [TopSpW-1:0]        out_top_spd_q;
  logic signed [AccelW-1:0] out_acc_q;
  logic [TopAcW-1:0]        out_top_acc_q;

  logic     in_fire;
  logic     out_load;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // datapath helpers
  logic signed [SpeedW-1:0] raw_sat;
  logic signed [18:0]       spd_ema;
  logic signed [18:0]       acc_ema;
  logic signed [SpeedW:0]   dv;
  logic [SpeedW-1:0]        dv_mag;
  logic [TimeW-1:0]         dt;
  logic [SpeedW-1:0]        raw_mag;
  logic [SpeedW-1:0]        avg_spd_mag;
  logic [TopAcW-1:0]        avg_acc_mag;
  logic [TopAcW-1:0]        quot_sat;

  stsm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (in_i.kind == KIND_LINK_LOST) ? ST_OUT : ST_SPEED;
        end
      end
      ST_SPEED: state_d = ST_BAND;
      ST_BAND:  state_d = acc_go_q ? ST_DIV : ST_OUT;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_ACCEL;
        end
      end
      ST_ACCEL: state_d = ST_PEAK;
      ST_PEAK:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready       = (state_q == ST_IDLE);
    out_load         = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);
    div_req.start    = (state_q == ST_BAND) && acc_go_q;
    // rounded quotient: (2*num + den) / (2*den)
    div_req.dividend = DivW'({num_q, 1'b0}) + DivW'(den_q);
    div_req.divisor  = {den_q, 1'b0};
  end

  assign in_fire = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------- datapath
  // Clamp the incoming speed to +-51200 before any use.
  always_comb begin
    if (in_i.speed_raw > SpeedW'(SpeedLimit)) begin
      raw_sat = SpeedW'(SpeedLimit);
    end else if (in_i.speed_raw < -SpeedW'(SpeedLimit)) begin
      raw_sat = -SpeedW'(SpeedLimit);
    end else begin
      raw_sat = in_i.speed_raw;
    end
  end

  assign spd_ema = ema_step({{2{avg_spd_q[SpeedW-1]}}, avg_spd_q},
                            {{2{raw_q[SpeedW-1]}}, raw_q}, speed_alpha_q);
  assign acc_ema = ema_step({avg_acc_q[AccelW-1], avg_acc_q},
                            {inst_q[AccelW-1], inst_q}, accel_alpha_q);

  assign dv      = {raw_q[SpeedW-1], raw_q} - {prev_spd_q[SpeedW-1], prev_spd_q};
  assign dv_mag  = dv[SpeedW] ? SpeedW'(-dv) : dv[SpeedW-1:0];
  assign dt      = now_q - prev_time_q;
  assign raw_mag = raw_q[SpeedW-1] ? SpeedW'(-raw_q) : raw_q;
  assign avg_spd_mag = avg_spd_q[SpeedW-1] ? SpeedW'(-avg_spd_q) : avg_spd_q;
  assign avg_acc_mag = avg_acc_q[AccelW-1] ? TopAcW'(-avg_acc_q) : avg_acc_q[TopAcW-1:0];
  assign quot_sat    = (div_rsp.quot > QuotW'(AccelLimit)) ? TopAcW'(AccelLimit)
                                                           : div_rsp.quot[TopAcW-1:0];

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_alpha_q <= SpeedAlphaRst;
      accel_alpha_q <= AccelAlphaRst;
      band_q        <= BandRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SPEED_ALPHA:     speed_alpha_q <= cfg_wdata_i[AlphaW-1:0];
        CFG_ACCEL_ALPHA:     accel_alpha_q <= cfg_wdata_i[AlphaW-1:0];
        CFG_STANDSTILL_BAND: band_q        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // architectural state, advanced step by step under the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_spd_q   <= '0;
      top_spd_q   <= '0;
      prev_spd_q  <= '0;
      prev_time_q <= '0;
      avg_acc_q   <= '0;
      top_acc_q   <= '0;
      acc_go_q    <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          // link lost: drop the averages and the timestamp, keep the peaks
          if (in_fire && in_i.kind == KIND_LINK_LOST) begin
            avg_spd_q   <= '0;
            avg_acc_q   <= '0;
            prev_time_q <= '0;
          end
        end
        ST_SPEED: begin
          avg_spd_q   <= spd_ema[SpeedW-1:0];
          if (raw_mag > {1'b0, top_spd_q}) begin
            top_spd_q <= raw_mag[TopSpW-1:0];
          end
          acc_go_q    <= (prev_time_q != '0) && (now_q > prev_time_q);
          prev_spd_q  <= raw_q;
          prev_time_q <= now_q;
        end
        ST_BAND: begin
          if (avg_spd_mag < {{(SpeedW-BandW){1'b0}}, band_q}) begin
            avg_spd_q <= '0;
          end
        end
        ST_ACCEL: avg_acc_q <= acc_ema[AccelW-1:0];
        ST_PEAK: begin
          if (avg_acc_mag > top_acc_q) begin
            top_acc_q <= avg_acc_mag;
          end
        end
        ST_DIV, ST_OUT: ;
        default: ;
      endcase
    end
  end

  // working registers: capture the beat, form the products, latch the quotient
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      raw_q <= raw_sat;
      now_q <= in_i.time_ms;
    end
    if (state_q == ST_SPEED) begin
      neg_q <= dv[SpeedW];
      num_q <= NumW'(dv_mag) * NumW'(AccelNumK);
      den_q <= DenW'(dt) * DenW'(AccelDenK);
    end
    if (state_q == ST_DIV && div_rsp.done) begin
      inst_q <= neg_q ? -AccelW'(quot_sat) : AccelW'(quot_sat);
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_spd_q     <= avg_spd_q;
      out_top_spd_q <= top_spd_q;
      out_acc_q     <= avg_acc_q;
      out_top_acc_q <= top_acc_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.smoothed_speed = out_spd_q;
  assign out_o.max_speed      = out_top_spd_q;
  assign out_o.accel_g        = out_acc_q;
  assign out_o.peak_g         = out_top_acc_q;

endmodule
